@@ rtl/assert_macros.svh @@
// Assertion macros shared by the maze carver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define DFSMC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfsmc assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define DFSMC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfsmc assertion failed");
`else
`define DFSMC_ASSERT_IMP(name, clk, rst, ante, cons)
`define DFSMC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ rtl/dfsmc_pkg.sv @@
// Shared widths, codes and helper functions of the maze carver.
package dfsmc_pkg;

   localparam int SIDE_W            = 5;
   localparam int COORD_W           = 4;
   localparam int RAND_W            = 16;
   localparam int ACT_W             = 2;
   localparam int DIR_W             = 2;
   localparam int ENTRY_W           = 2 * COORD_W;
   localparam int COORD_LIMIT       = 1 << COORD_W;
   localparam int DEFAULT_GRID_SIDE = 16;

   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(16);

   // Result action codes.
   localparam logic [ACT_W-1:0] ACT_CARVE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BACK  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_IDLE  = 2'd2;

   // Direction codes, in the order the neighbors are scanned.
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

   // Remainder of a random word by three. Since four is one more than three,
   // the base-4 digits can be summed and folded until the value is small.
   function automatic logic [1:0] mod3_rand(input logic [RAND_W-1:0] v);
      logic [4:0] s;
      logic [3:0] t;
      logic [2:0] u;
      s = '0;
      for (int i = 0; i < RAND_W / 2; i++) begin
         s = s + {3'b000, v[2*i +: 2]};
      end
      t = {1'b0, s[4:2]} + {2'b00, s[1:0]};
      u = {1'b0, t[3:2]} + {1'b0, t[1:0]};
      if (u >= 3'd3) begin
         u = u - 3'd3;
      end
      return u[1:0];
   endfunction

endpackage

@@ rtl/dfsmc_visit_map.sv @@
// Visited map memory: one word per grid row, two registered read ports, one write port.
module dfsmc_visit_map #(
   parameter int ROW_W = dfsmc_pkg::COORD_W
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [ROW_W-1:0]         rd_addr_a,
   input  logic [ROW_W-1:0]         rd_addr_b,
   output logic [(1 << ROW_W)-1:0]  rd_data_a,
   output logic [(1 << ROW_W)-1:0]  rd_data_b,
   input  logic                     wr_en,
   input  logic [ROW_W-1:0]         wr_addr,
   input  logic [(1 << ROW_W)-1:0]  wr_data
);

   localparam int MAP_W    = 1 << ROW_W;
   localparam int MAP_ROWS = 1 << ROW_W;

   logic [MAP_W-1:0] mem [MAP_ROWS];
   logic [MAP_W-1:0] rd_a_ff;
   logic [MAP_W-1:0] rd_b_ff;

   // Row write from the clearing pass or from a carve step.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Both rows are read together; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/dfsmc_path_stack.sv @@
// Path stack memory holding the packed row and column of each cell on the path.
module dfsmc_path_stack #(
   parameter int DEPTH = dfsmc_pkg::COORD_LIMIT * dfsmc_pkg::COORD_LIMIT
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [dfsmc_pkg::ENTRY_W-1:0]   rd_data,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [dfsmc_pkg::ENTRY_W-1:0]   wr_data
);

   import dfsmc_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_ff;

   // Push writes the cell being left.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The top entry is fetched ahead of each step, in case it pops.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

@@ rtl/dfs_maze_carver_core.sv @@
// Top level of the depth-first maze carver: step sequencer, state registers and result register.
//
// Channel  Dir  Handshake        Beat contents
// req_     in   valid / ready    restart, random_value
// rsp_     out  valid / ready    from/to cell, action, direction, done_res
// csr_     in   write enable     side_in_use
//
// Each step is split: on acceptance the visited rows above and below the current
// cell and the stack top are read, and in the execute state the step decides and writes back.
// The split follows from the registered read ports of the visited map.
// Reset, a restart beat and a side write start a clearing pass over the 2**ROW_W map rows
// (16 at the default size), during which req_ready is low.
// While a finished result waits on rsp_ready, the next beat is still accepted and
// stalls in the execute state until the result register frees up.
`include "assert_macros.svh"

module dfs_maze_carver_core #(
   parameter int GRID_SIDE = dfsmc_pkg::DEFAULT_GRID_SIDE
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_restart,
   input  logic [dfsmc_pkg::RAND_W-1:0]    req_random_value,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dfsmc_pkg::COORD_W-1:0]   rsp_from_col,
   output logic [dfsmc_pkg::COORD_W-1:0]   rsp_from_row,
   output logic [dfsmc_pkg::COORD_W-1:0]   rsp_to_col,
   output logic [dfsmc_pkg::COORD_W-1:0]   rsp_to_row,
   output logic [dfsmc_pkg::ACT_W-1:0]     rsp_action,
   output logic [dfsmc_pkg::DIR_W-1:0]     rsp_direction,
   output logic                            rsp_done_res,

   input  logic                            csr_wr_en,
   input  logic [dfsmc_pkg::SIDE_W-1:0]    csr_wr_data
);

   import dfsmc_pkg::*;

   localparam int MAX_SIDE    = (GRID_SIDE < COORD_LIMIT) ? GRID_SIDE : COORD_LIMIT;
   localparam int ROW_W       = $clog2(MAX_SIDE);
   localparam int MAP_W       = 1 << ROW_W;
   localparam int MAP_ROWS    = 1 << ROW_W;
   localparam int STACK_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [ROW_W-1:0]      clr_row_ff, clr_row_in;
   logic [SIDE_W-1:0]     side_ff, side_in;
   logic [COORD_W-1:0]    cur_col_ff, cur_col_in;
   logic [COORD_W-1:0]    cur_row_ff, cur_row_in;
   logic [MAP_W-1:0]      cur_bits_ff, cur_bits_in;
   logic [CNT_W-1:0]      sp_ff, sp_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  restart_ff, restart_in;
   logic [1:0]            rnd_m3_ff, rnd_m3_in;
   logic [1:0]            rnd_lo_ff, rnd_lo_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]    rsp_from_col_ff, rsp_from_col_in;
   logic [COORD_W-1:0]    rsp_from_row_ff, rsp_from_row_in;
   logic [COORD_W-1:0]    rsp_to_col_ff, rsp_to_col_in;
   logic [COORD_W-1:0]    rsp_to_row_ff, rsp_to_row_in;
   logic [ACT_W-1:0]      rsp_action_ff, rsp_action_in;
   logic [DIR_W-1:0]      rsp_direction_ff, rsp_direction_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic                  req_fire;
   logic                  commit;
   logic                  start_clear;

   logic [SIDE_W-1:0]     eff_side;
   logic [2*SIDE_W-1:0]   total_wide;
   logic [CNT_W-1:0]      total_cnt;

   logic [ROW_W-1:0]      map_rd_addr_up;
   logic [ROW_W-1:0]      map_rd_addr_dn;
   logic [MAP_W-1:0]      up_bits;
   logic [MAP_W-1:0]      dn_bits;
   logic                  map_wr_en;
   logic [ROW_W-1:0]      map_wr_addr;
   logic [MAP_W-1:0]      map_wr_data;

   logic [CNT_W-1:0]      sp_minus1;
   logic [ENTRY_W-1:0]    stk_rd_data;
   logic                  stk_wr_en;

   logic [COORD_W-1:0]    col_r;
   logic [COORD_W-1:0]    col_l;
   logic [COORD_W-1:0]    row_u;
   logic [COORD_W-1:0]    row_d;
   logic [3:0]            open_nbr;
   logic [2:0]            open_cnt;
   logic [1:0]            pick;
   logic [2:0]            seen_cnt;
   logic                  found;
   logic [DIR_W-1:0]      sel_dir;
   logic [COORD_W-1:0]    new_col;
   logic [COORD_W-1:0]    new_row;
   logic [MAP_W-1:0]      base_bits;
   logic [MAP_W-1:0]      new_bits;
   logic [COORD_W-1:0]    par_col;
   logic [COORD_W-1:0]    par_row;
   logic [MAP_W-1:0]      par_bits;

   // Handshakes. A side write takes priority over a new beat.
   assign req_ready   = (state_ff == S_IDLE) && !csr_wr_en;
   assign req_fire    = req_valid && req_ready;
   assign commit      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign start_clear = csr_wr_en || (commit && restart_ff);

   // Effective side, clamped to the supported range, and the cell total.
   always_comb begin
      eff_side = side_ff;
      if (side_ff < SIDE_W'(2)) begin
         eff_side = SIDE_W'(2);
      end else if (side_ff > SIDE_W'(MAX_SIDE)) begin
         eff_side = SIDE_W'(MAX_SIDE);
      end
   end

   assign total_wide = {{SIDE_W{1'b0}}, eff_side} * {{SIDE_W{1'b0}}, eff_side};
   assign total_cnt  = total_wide[CNT_W-1:0];

   // Read addresses for the rows above and below, and the stack top.
   assign row_u          = cur_row_ff - COORD_W'(1);
   assign row_d          = cur_row_ff + COORD_W'(1);
   assign col_r          = cur_col_ff + COORD_W'(1);
   assign col_l          = cur_col_ff - COORD_W'(1);
   assign map_rd_addr_up = row_u[ROW_W-1:0];
   assign map_rd_addr_dn = row_d[ROW_W-1:0];
   assign sp_minus1      = sp_ff - CNT_W'(1);

   dfsmc_visit_map #(
      .ROW_W     (ROW_W)
   ) u_visit_map (
      .clock     (clock),
      .rd_en     (req_fire),
      .rd_addr_a (map_rd_addr_up),
      .rd_addr_b (map_rd_addr_dn),
      .rd_data_a (up_bits),
      .rd_data_b (dn_bits),
      .wr_en     (map_wr_en),
      .wr_addr   (map_wr_addr),
      .wr_data   (map_wr_data)
   );

   dfsmc_path_stack #(
      .DEPTH     (STACK_DEPTH)
   ) u_path_stack (
      .clock     (clock),
      .rd_en     (req_fire),
      .rd_addr   (sp_minus1[STK_AW-1:0]),
      .rd_data   (stk_rd_data),
      .wr_en     (stk_wr_en),
      .wr_addr   (sp_ff[STK_AW-1:0]),
      .wr_data   ({cur_row_ff, cur_col_ff})
   );

   // Open neighbors of the current cell, scanned up, right, down, left.
   always_comb begin
      open_nbr[0] = (cur_row_ff != '0) && !up_bits[cur_col_ff[ROW_W-1:0]];
      open_nbr[1] = ((SIDE_W'(cur_col_ff) + SIDE_W'(1)) < eff_side) &&
                    !cur_bits_ff[col_r[ROW_W-1:0]];
      open_nbr[2] = ((SIDE_W'(cur_row_ff) + SIDE_W'(1)) < eff_side) &&
                    !dn_bits[cur_col_ff[ROW_W-1:0]];
      open_nbr[3] = (cur_col_ff != '0) && !cur_bits_ff[col_l[ROW_W-1:0]];
   end

   assign open_cnt = 3'($countones(open_nbr));

   // Pick index: the random word reduced by the number of open neighbors.
   always_comb begin
      case (open_cnt)
         3'd2:    pick = {1'b0, rnd_lo_ff[0]};
         3'd3:    pick = rnd_m3_ff;
         3'd4:    pick = rnd_lo_ff;
         default: pick = 2'd0;
      endcase
   end

   // Direction of the chosen open neighbor.
   always_comb begin
      seen_cnt = '0;
      found    = 1'b0;
      sel_dir  = DIR_UP;
      for (int i = 0; i < 4; i++) begin
         if (open_nbr[i] && !found) begin
            if (seen_cnt[1:0] == pick) begin
               sel_dir = DIR_W'(i);
               found   = 1'b1;
            end
            seen_cnt = seen_cnt + 3'd1;
         end
      end
   end

   // Target cell and the row word it lands in, with its visited bit set.
   always_comb begin
      case (sel_dir)
         DIR_UP: begin
            new_row   = row_u;
            new_col   = cur_col_ff;
            base_bits = up_bits;
         end
         DIR_RIGHT: begin
            new_row   = cur_row_ff;
            new_col   = col_r;
            base_bits = cur_bits_ff;
         end
         DIR_DOWN: begin
            new_row   = row_d;
            new_col   = cur_col_ff;
            base_bits = dn_bits;
         end
         default: begin
            new_row   = cur_row_ff;
            new_col   = col_l;
            base_bits = cur_bits_ff;
         end
      endcase
      new_bits = base_bits | (MAP_W'(1) << new_col[ROW_W-1:0]);
   end

   // A popped cell is always adjacent, so its row is one already at hand.
   assign par_row = stk_rd_data[ENTRY_W-1:COORD_W];
   assign par_col = stk_rd_data[COORD_W-1:0];

   always_comb begin
      if (par_row == cur_row_ff) begin
         par_bits = cur_bits_ff;
      end else if (par_row == row_u) begin
         par_bits = up_bits;
      end else begin
         par_bits = dn_bits;
      end
   end

   // Step sequencer: clearing pass, wait for a beat, then decide and write back.
   always_comb begin
      state_in         = state_ff;
      clr_row_in       = clr_row_ff;
      side_in          = csr_wr_en ? csr_wr_data : side_ff;
      cur_col_in       = cur_col_ff;
      cur_row_in       = cur_row_ff;
      cur_bits_in      = cur_bits_ff;
      sp_in            = sp_ff;
      count_in         = count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_from_col_in  = rsp_from_col_ff;
      rsp_from_row_in  = rsp_from_row_ff;
      rsp_to_col_in    = rsp_to_col_ff;
      rsp_to_row_in    = rsp_to_row_ff;
      rsp_action_in    = rsp_action_ff;
      rsp_direction_in = rsp_direction_ff;
      rsp_done_in      = rsp_done_ff;
      map_wr_en        = 1'b0;
      map_wr_addr      = clr_row_ff;
      map_wr_data      = '0;
      stk_wr_en        = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_data = (clr_row_ff == '0) ? MAP_W'(1) : '0;
            if (clr_row_ff == ROW_W'(MAP_ROWS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_row_in = clr_row_ff + ROW_W'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in         = S_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_from_col_in  = cur_col_ff;
               rsp_from_row_in  = cur_row_ff;
               rsp_to_col_in    = cur_col_ff;
               rsp_to_row_in    = cur_row_ff;
               rsp_action_in    = ACT_IDLE;
               rsp_direction_in = DIR_UP;
               rsp_done_in      = (count_ff >= total_cnt);
               if (restart_ff) begin
                  // Restart: report the origin, the clearing pass follows.
                  rsp_from_col_in = '0;
                  rsp_from_row_in = '0;
                  rsp_to_col_in   = '0;
                  rsp_to_row_in   = '0;
                  rsp_done_in     = 1'b0;
               end else if (count_ff >= total_cnt) begin
                  // Maze complete: nothing moves.
               end else if (open_cnt != '0) begin
                  // Carve into the chosen neighbor and push the cell left behind.
                  map_wr_en        = 1'b1;
                  map_wr_addr      = new_row[ROW_W-1:0];
                  map_wr_data      = new_bits;
                  stk_wr_en        = (sp_ff < CNT_W'(STACK_DEPTH));
                  sp_in            = stk_wr_en ? sp_ff + CNT_W'(1) : sp_ff;
                  count_in         = count_ff + CNT_W'(1);
                  cur_col_in       = new_col;
                  cur_row_in       = new_row;
                  cur_bits_in      = new_bits;
                  rsp_to_col_in    = new_col;
                  rsp_to_row_in    = new_row;
                  rsp_action_in    = ACT_CARVE;
                  rsp_direction_in = sel_dir;
                  rsp_done_in      = (count_in >= total_cnt);
               end else if (sp_ff != '0) begin
                  // Dead end: return to the cell on top of the stack.
                  sp_in         = sp_minus1;
                  cur_col_in    = par_col;
                  cur_row_in    = par_row;
                  cur_bits_in   = par_bits;
                  rsp_to_col_in = par_col;
                  rsp_to_row_in = par_row;
                  rsp_action_in = ACT_BACK;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      // Side write or restart: back to the origin and wipe the map.
      if (start_clear) begin
         state_in    = S_CLEAR;
         clr_row_in  = '0;
         cur_col_in  = '0;
         cur_row_in  = '0;
         cur_bits_in = MAP_W'(1);
         sp_in       = '0;
         count_in    = CNT_W'(1);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_row_ff   <= '0;
         side_ff      <= SIDE_RESET;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cur_bits_ff  <= MAP_W'(1);
         sp_ff        <= '0;
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         side_ff      <= side_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         cur_bits_ff  <= cur_bits_in;
         sp_ff        <= sp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured beat: restart flag and the random word, already reduced.
   assign restart_in = req_restart;
   assign rnd_m3_in  = mod3_rand(req_random_value);
   assign rnd_lo_in  = req_random_value[1:0];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         restart_ff <= restart_in;
         rnd_m3_ff  <= rnd_m3_in;
         rnd_lo_ff  <= rnd_lo_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_from_col_ff  <= rsp_from_col_in;
      rsp_from_row_ff  <= rsp_from_row_in;
      rsp_to_col_ff    <= rsp_to_col_in;
      rsp_to_row_ff    <= rsp_to_row_in;
      rsp_action_ff    <= rsp_action_in;
      rsp_direction_ff <= rsp_direction_in;
      rsp_done_ff      <= rsp_done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_from_col  = rsp_from_col_ff;
   assign rsp_from_row  = rsp_from_row_ff;
   assign rsp_to_col    = rsp_to_col_ff;
   assign rsp_to_row    = rsp_to_row_ff;
   assign rsp_action    = rsp_action_ff;
   assign rsp_direction = rsp_direction_ff;
   assign rsp_done_res  = rsp_done_ff;

   // The path is always shorter than the number of visited cells.
   `DFSMC_ASSERT_IMP(a_path_below_count, clock, reset, 1'b1, sp_ff < count_ff)
   // The visited count never passes the cells in use.
   `DFSMC_ASSERT_IMP(a_count_in_range, clock, reset, 1'b1, count_ff <= total_cnt)
   // A restart beat is followed by the clearing pass.
   `DFSMC_ASSERT_NEXT(a_restart_clears, clock, reset, commit && restart_ff, state_ff == S_CLEAR)

endmodule
